@@ hw/rtl/mrtu_pkg.sv @@
package mrtu_pkg;

  localparam int FRAME_BUFFER_SIZE = 256;

  localparam logic [15:0] GAP_LIMIT_RESET = 16'd100;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;
  localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

  // Function codes whose response carries a byte count
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;

  // Register map (word index)
  localparam logic REG_GAP_LIMIT = 1'b0;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // CRC-16/MODBUS, one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/modbus_rtu_response_parser.sv @@
// Modbus RTU response parser. Each input word is either a received byte (kind 0) or one
// time tick (kind 1); ticks count idle time and give no result, and a byte that arrives
// after at least gap_limit idle ticks (register 0, reset 100) restarts parsing at the node
// id. Every received byte yields exactly one result word: the node id, function code and
// register address held for the current frame, the payload byte with its position while
// in the data phase, the frame byte count modulo FRAME_BUFFER_SIZE, and on the CRC high
// byte frame_done with the CRC-16/MODBUS compare in crc_ok. One word is taken per clock
// cycle while no result is stalled, and its result is registered in the cycle after; the
// parse step and the byte-wide CRC update sit between the input handshake and a single
// output register, and input stalls only while that register holds a result not yet taken.
module modbus_rtu_response_parser #(
  parameter int FRAME_BUFFER_SIZE = mrtu_pkg::FRAME_BUFFER_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_done,
  output logic        crc_ok,
  output logic [7:0]  node_address,
  output logic [7:0]  function_code,
  output logic [15:0] register_address,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic [7:0]  payload_position,
  output logic [7:0]  frame_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mrtu_pkg::*;

  localparam int BPOS_W = $clog2(FRAME_BUFFER_SIZE);
  localparam logic [BPOS_W-1:0] BPOS_LAST = BPOS_W'(FRAME_BUFFER_SIZE - 1);

  typedef enum logic [7:0] {
    ST_ID    = 8'b0000_0001,
    ST_FUNC  = 8'b0000_0010,
    ST_LEN   = 8'b0000_0100,
    ST_REG_L = 8'b0000_1000,
    ST_REG_H = 8'b0001_0000,
    ST_DATA  = 8'b0010_0000,
    ST_CRC_L = 8'b0100_0000,
    ST_CRC_H = 8'b1000_0000
  } parse_state_t;

  parse_state_t      parse_state, parse_state_next, state_cur;
  logic [15:0]       gap_limit;
  logic [15:0]       running_crc, running_crc_next, crc_cur, crc_upd;
  logic [15:0]       received_crc, received_crc_next;
  logic [7:0]        payload_count, payload_count_next, pcount_cur, pcount_inc;
  logic [7:0]        payload_length, payload_length_next;
  logic [7:0]        held_node, held_node_next;
  logic [7:0]        held_function, held_function_next;
  logic [15:0]       held_register, held_register_next;
  logic [BPOS_W-1:0] byte_position, byte_position_next, bpos_cur, bpos_inc;
  logic [15:0]       idle_ticks;

  logic byte_take, tick_take, restart;
  logic done_c, ok_c, pvalid_c;
  logic [7:0] pbyte_c, ppos_c;

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_GAP_LIMIT) begin
      prdata = {16'h0000, gap_limit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= GAP_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_GAP_LIMIT) begin
      gap_limit <= pwdata[15:0];
    end
  end

  // Handshake: one output register, refilled in the cycle it drains
  assign in_ready  = !out_valid || out_ready;
  assign byte_take = in_valid && in_ready && kind == KIND_BYTE;
  assign tick_take = in_valid && in_ready && kind == KIND_TICK;

  assign restart   = idle_ticks >= gap_limit;
  assign state_cur = restart ? ST_ID : parse_state;
  assign crc_cur   = restart ? CRC_INIT : running_crc;
  assign pcount_cur = restart ? 8'h00 : payload_count;
  assign bpos_cur  = restart ? '0 : byte_position;
  assign bpos_inc  = (bpos_cur == BPOS_LAST) ? '0 : bpos_cur + 1'b1;
  assign pcount_inc = pcount_cur + 8'd1;
  assign crc_upd   = crc16_byte(crc_cur, rx_byte);

  always_comb begin
    parse_state_next    = state_cur;
    running_crc_next    = crc_cur;
    received_crc_next   = received_crc;
    payload_count_next  = pcount_cur;
    payload_length_next = payload_length;
    held_node_next      = held_node;
    held_function_next  = held_function;
    held_register_next  = held_register;
    byte_position_next  = bpos_inc;
    done_c   = 1'b0;
    ok_c     = 1'b0;
    pvalid_c = 1'b0;
    pbyte_c  = 8'h00;
    ppos_c   = 8'h00;
    case (state_cur)
      ST_ID: begin
        held_node_next     = rx_byte;
        held_register_next = 16'h0000;
        running_crc_next   = crc_upd;
        parse_state_next   = ST_FUNC;
      end
      ST_FUNC: begin
        held_function_next = rx_byte;
        running_crc_next   = crc_upd;
        if (rx_byte inside {FC_READ_HOLDING, FC_READ_INPUT}) begin
          parse_state_next = ST_LEN;
        end else begin
          parse_state_next = ST_REG_L;
        end
      end
      ST_LEN: begin
        payload_length_next = rx_byte;
        payload_count_next  = 8'h00;
        running_crc_next    = crc_upd;
        parse_state_next    = ST_DATA;
      end
      ST_REG_L: begin
        held_register_next = {8'h00, rx_byte};
        running_crc_next   = crc_upd;
        parse_state_next   = ST_REG_H;
      end
      ST_REG_H: begin
        held_register_next  = {rx_byte, held_register[7:0]};
        payload_length_next = 8'd2;
        payload_count_next  = 8'h00;
        running_crc_next    = crc_upd;
        parse_state_next    = ST_DATA;
      end
      ST_DATA: begin
        pvalid_c           = 1'b1;
        pbyte_c            = rx_byte;
        ppos_c             = pcount_cur;
        payload_count_next = pcount_inc;
        running_crc_next   = crc_upd;
        // a zero count still ends after one byte
        if (pcount_inc >= payload_length) begin
          parse_state_next = ST_CRC_L;
        end
      end
      ST_CRC_L: begin
        received_crc_next = {8'h00, rx_byte};
        parse_state_next  = ST_CRC_H;
      end
      ST_CRC_H: begin
        received_crc_next  = {rx_byte, received_crc[7:0]};
        done_c             = 1'b1;
        ok_c               = crc_cur == {rx_byte, received_crc[7:0]};
        parse_state_next   = ST_ID;
        running_crc_next   = CRC_INIT;
        payload_count_next = 8'h00;
        byte_position_next = '0;
      end
      default: begin
        parse_state_next = ST_ID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state    <= ST_ID;
      running_crc    <= CRC_INIT;
      received_crc   <= 16'h0000;
      payload_count  <= 8'h00;
      payload_length <= 8'h00;
      held_node      <= 8'h00;
      held_function  <= 8'h00;
      held_register  <= 16'h0000;
      byte_position  <= '0;
      idle_ticks     <= 16'h0000;
    end else if (byte_take) begin
      parse_state    <= parse_state_next;
      running_crc    <= running_crc_next;
      received_crc   <= received_crc_next;
      payload_count  <= payload_count_next;
      payload_length <= payload_length_next;
      held_node      <= held_node_next;
      held_function  <= held_function_next;
      held_register  <= held_register_next;
      byte_position  <= byte_position_next;
      idle_ticks     <= 16'h0000;
    end else if (tick_take && idle_ticks != IDLE_MAX) begin
      idle_ticks <= idle_ticks + 16'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (byte_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      frame_done       <= done_c;
      crc_ok           <= ok_c;
      node_address     <= held_node_next;
      function_code    <= held_function_next;
      register_address <= held_register_next;
      payload_byte     <= pbyte_c;
      payload_valid    <= pvalid_c;
      payload_position <= ppos_c;
      frame_length     <= 8'(bpos_inc);
    end
  end

endmodule

@@ hw/rtl/mrtu_checker.sv @@
module mrtu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       frame_done,
  input logic       crc_ok,
  input logic       payload_valid,
  input logic [7:0] payload_byte,
  input logic [7:0] frame_length
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(frame_length))
    else $error("stalled result changed");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input stalls only behind an untaken result
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without backpressure");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && crc_ok |-> frame_done)
    else $error("crc_ok outside frame end");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> !frame_done)
    else $error("payload byte flagged as frame end");

endmodule

bind modbus_rtu_response_parser mrtu_checker u_mrtu_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .frame_done    (frame_done),
  .crc_ok        (crc_ok),
  .payload_valid (payload_valid),
  .payload_byte  (payload_byte),
  .frame_length  (frame_length)
);

@@ sim/modbus_rtu_checker.sv @@
`timescale 1ns / 100ps

module modbus_rtu_checker
  import mrtu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        frame_done,
  input  logic        crc_ok,
  input  logic [7:0]  node_address,
  input  logic [7:0]  function_code,
  input  logic [15:0] register_address,
  input  logic [7:0]  payload_byte,
  input  logic        payload_valid,
  input  logic [7:0]  payload_position,
  input  logic [7:0]  frame_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          expected_count,
  output int          mismatches
);

  typedef enum logic [2:0] {
    AWAIT_NODE,
    AWAIT_FUNC,
    AWAIT_LEN,
    AWAIT_REG_LO,
    AWAIT_REG_HI,
    AWAIT_DATA,
    AWAIT_CRC_LO,
    AWAIT_CRC_HI
  } rx_phase_t;

  typedef struct packed {
    logic        frame_done;
    logic        crc_ok;
    logic [7:0]  node_address;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [7:0]  payload_position;
    logic [7:0]  frame_length;
  } response_word_t;

  response_word_t expected_q[$];

  rx_phase_t   phase;
  logic [15:0] gap_lim;
  logic [15:0] idle_run;
  logic [15:0] crc_run;
  logic [15:0] crc_rx;
  logic [15:0] addr_held;
  logic [7:0]  data_seen;
  logic [7:0]  data_len;
  logic [7:0]  node_id;
  logic [7:0]  func_code;
  logic [7:0]  frame_pos;
  int          word_no;

  function automatic logic [15:0] crc_after(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] v;
    v = c ^ {8'h00, d};
    repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY_REFL) : (v >> 1);
    return v;
  endfunction

  task automatic restart_parse();
    phase = AWAIT_NODE;
    crc_run = CRC_INIT;
    data_seen = '0;
    frame_pos = '0;
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("word %0d: %s is %0h, expected %0h", word_no, field, got, want);
    mismatches++;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    response_word_t w;
    w = '0;
    if (idle_run >= gap_lim) restart_parse();
    idle_run = '0;
    frame_pos = 8'((frame_pos + 1) % FRAME_BUFFER_SIZE);
    w.frame_length = frame_pos;
    case (phase)
      AWAIT_NODE: begin
        node_id = b;
        addr_held = '0;
        crc_run = crc_after(crc_run, b);
        phase = AWAIT_FUNC;
      end
      AWAIT_FUNC: begin
        func_code = b;
        crc_run = crc_after(crc_run, b);
        phase = (b == FC_READ_HOLDING || b == FC_READ_INPUT) ? AWAIT_LEN : AWAIT_REG_LO;
      end
      AWAIT_LEN: begin
        data_len = b;
        data_seen = '0;
        crc_run = crc_after(crc_run, b);
        phase = AWAIT_DATA;
      end
      AWAIT_REG_LO: begin
        addr_held = {8'h00, b};
        crc_run = crc_after(crc_run, b);
        phase = AWAIT_REG_HI;
      end
      AWAIT_REG_HI: begin
        addr_held[15:8] = b;
        data_len = 8'd2;
        data_seen = '0;
        crc_run = crc_after(crc_run, b);
        phase = AWAIT_DATA;
      end
      AWAIT_DATA: begin
        w.payload_valid = 1'b1;
        w.payload_byte = b;
        w.payload_position = data_seen;
        data_seen = data_seen + 8'd1;
        // a zero length still ends after one byte
        if (data_seen >= data_len) phase = AWAIT_CRC_LO;
        crc_run = crc_after(crc_run, b);
      end
      AWAIT_CRC_LO: begin
        crc_rx = {8'h00, b};
        phase = AWAIT_CRC_HI;
      end
      default: begin
        crc_rx[15:8] = b;
        w.frame_done = 1'b1;
        w.crc_ok = (crc_run == crc_rx);
        restart_parse();
      end
    endcase
    w.node_address = node_id;
    w.function_code = func_code;
    w.register_address = addr_held;
    expected_q = {expected_q, w};
  endtask

  task automatic check_word();
    response_word_t want;
    word_no++;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected word, frame_length", frame_length, '0);
    end else begin
      want = expected_q.pop_front();
      if (frame_done !== want.frame_done)
        report_mismatch("frame_done", frame_done, want.frame_done);
      if (crc_ok !== want.crc_ok)
        report_mismatch("crc_ok", crc_ok, want.crc_ok);
      if (node_address !== want.node_address)
        report_mismatch("node_address", node_address, want.node_address);
      if (function_code !== want.function_code)
        report_mismatch("function_code", function_code, want.function_code);
      if (register_address !== want.register_address)
        report_mismatch("register_address", register_address, want.register_address);
      if (payload_byte !== want.payload_byte)
        report_mismatch("payload_byte", payload_byte, want.payload_byte);
      if (payload_valid !== want.payload_valid)
        report_mismatch("payload_valid", payload_valid, want.payload_valid);
      if (payload_position !== want.payload_position)
        report_mismatch("payload_position", payload_position, want.payload_position);
      if (frame_length !== want.frame_length)
        report_mismatch("frame_length", frame_length, want.frame_length);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      gap_lim = GAP_LIMIT_RESET;
      idle_run = '0;
      crc_rx = '0;
      addr_held = '0;
      data_len = '0;
      node_id = '0;
      func_code = '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_GAP_LIMIT, 2'b00})
        gap_lim = pwdata[15:0];
      if (out_valid && out_ready) check_word();
      if (in_valid && in_ready) begin
        if (kind == KIND_TICK) begin
          if (idle_run != IDLE_MAX) idle_run = idle_run + 16'd1;
        end else begin
          predict_byte(rx_byte);
        end
      end
    end
    expected_count <= expected_q.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import mrtu_pkg::*;

  localparam logic [7:0] FC_WRITE_SINGLE   = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTIPLE = 8'd16;
  localparam logic [7:0] FC_UNLISTED       = 8'hFF;
  localparam int WHOLE_FRAME = 1000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KIND_BYTE;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        frame_done;
  logic        crc_ok;
  logic [7:0]  node_address;
  logic [7:0]  function_code;
  logic [15:0] register_address;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic [7:0]  payload_position;
  logic [7:0]  frame_length;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'b000;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  int   expected_count;
  int   mismatches;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   words_sent = 0;
  int   gap_setting = GAP_LIMIT_RESET;
  int   stall_left = 0;
  bit   stall_request = 1'b0;
  logic [7:0] frame_body[$];

  modbus_rtu_response_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_done(frame_done), .crc_ok(crc_ok), .node_address(node_address),
    .function_code(function_code), .register_address(register_address),
    .payload_byte(payload_byte), .payload_valid(payload_valid),
    .payload_position(payload_position), .frame_length(frame_length),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  modbus_rtu_checker monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_done(frame_done), .crc_ok(crc_ok), .node_address(node_address),
    .function_code(function_code), .register_address(register_address),
    .payload_byte(payload_byte), .payload_valid(payload_valid),
    .payload_position(payload_position), .frame_length(frame_length),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .expected_count(expected_count), .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [15:0] modbus_crc(input logic [15:0] c, input logic [7:0] d);
    c = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    return c;
  endfunction

  task automatic send_word(input logic k, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(KIND_TICK, 8'($urandom_range(255)));
  endtask

  // append the CRC to a copy of frame_body and send the first cut bytes, ticks between some
  task automatic send_frame(input bit corrupt, input int cut, input int tick_min,
                            input int tick_max, input int tick_pct);
    logic [15:0] crc;
    logic [7:0]  wire_q[$];
    crc = CRC_INIT;
    foreach (frame_body[i]) crc = modbus_crc(crc, frame_body[i]);
    if (corrupt) crc = crc ^ 16'($urandom_range(65535, 1));
    wire_q = frame_body;
    wire_q = {wire_q, crc[7:0], crc[15:8]};
    for (int i = 0; i < cut && i < wire_q.size(); i++) begin
      if (i > 0 && tick_max > 0 && $urandom_range(99) < tick_pct)
        send_ticks($urandom_range(tick_max, tick_min));
      send_word(KIND_BYTE, wire_q[i]);
    end
  endtask

  task automatic random_frame();
    int len;
    int cut;
    int tick_max;
    logic [7:0] fc;
    frame_body.delete();
    frame_body = {frame_body, 8'($urandom_range(255))};
    case ($urandom_range(9))
      0, 1, 2: fc = FC_READ_HOLDING;
      3, 4, 5: fc = FC_READ_INPUT;
      6:       fc = FC_WRITE_SINGLE;
      7:       fc = FC_WRITE_MULTIPLE;
      default: fc = 8'($urandom_range(255));
    endcase
    frame_body = {frame_body, fc};
    if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) begin
      if ($urandom_range(79) == 0) len = 255;
      else if ($urandom_range(19) == 0) len = $urandom_range(255);
      else len = $urandom_range(6);
      frame_body = {frame_body, 8'(len)};
      if (len == 0) len = 1;
    end else begin
      frame_body = {frame_body, 8'($urandom_range(255))};
      frame_body = {frame_body, 8'($urandom_range(255))};
      len = 2;
    end
    repeat (len) frame_body = {frame_body, 8'($urandom_range(255))};
    tick_max = (gap_setting > 1) ? ((gap_setting - 1 < 40) ? gap_setting - 1 : 40) : 0;
    cut = WHOLE_FRAME;
    if (gap_setting <= 64 && $urandom_range(9) == 0)
      cut = $urandom_range(frame_body.size() + 1, 1);
    send_frame($urandom_range(7) == 0, cut, 1, tick_max, 25);
    // broken frames and noise only where a gap can resync the parser
    if (gap_setting <= 64) begin
      if ($urandom_range(11) == 0) begin
        repeat ($urandom_range(4, 1)) send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
        cut = 0;
      end
      if (cut != WHOLE_FRAME || $urandom_range(2) == 0)
        send_ticks(gap_setting + $urandom_range(2));
    end
  endtask

  task automatic random_frames(input int count);
    words_sent = 0;
    while (words_sent < count) random_frame();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < 20000 && expected_count != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_gap_limit(input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_GAP_LIMIT, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    gap_setting = value;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 60;

    frame_body = {8'h11, FC_READ_HOLDING, 8'h02, 8'h00, 8'hFF};
    send_frame(1'b0, WHOLE_FRAME, 0, 0, 0);
    frame_body = {8'h00, FC_READ_INPUT, 8'h00, 8'h5A};
    send_frame(1'b0, WHOLE_FRAME, 0, 0, 0);
    frame_body = {8'hFF, FC_WRITE_SINGLE, 8'h34, 8'h12, 8'hAB, 8'hCD};
    send_frame(1'b0, WHOLE_FRAME, 0, 0, 0);
    frame_body = {8'h01, FC_READ_HOLDING, 8'h01, 8'h80};
    send_frame(1'b1, WHOLE_FRAME, 0, 0, 0);
    frame_body = {8'h7F, FC_UNLISTED, 8'hFF, 8'hFF, 8'h00, 8'h01};
    send_frame(1'b0, WHOLE_FRAME, 0, 0, 0);
    settle();

    write_gap_limit(16'd8);
    // drop a half frame by letting the gap run out
    send_word(KIND_BYTE, 8'h22);
    send_word(KIND_BYTE, FC_READ_HOLDING);
    send_ticks(gap_setting);
    frame_body = {8'h22, FC_WRITE_MULTIPLE, 8'h00, 8'h01, 8'h00, 8'h02};
    send_frame(1'b0, WHOLE_FRAME, 0, 0, 0);
    // one tick short of the gap before every byte but the first: no restart
    frame_body = {8'h5A, FC_READ_INPUT, 8'h00, 8'hA5};
    send_frame(1'b0, WHOLE_FRAME, gap_setting - 1, gap_setting - 1, 100);
    settle();

    write_gap_limit(16'd6);
    random_frames(500);
    settle();

    send_idle_pct = 60;
    recv_idle_pct = 27;
    write_gap_limit(16'd1);
    random_frames(200);
    settle();
    write_gap_limit(16'd0);
    random_frames(60);
    settle();
    write_gap_limit(16'd200);
    random_frames(200);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gap_limit(16'd64);
    // a long gap drops a half frame, then a full-length read response follows
    send_word(KIND_BYTE, 8'h44);
    send_word(KIND_BYTE, FC_READ_INPUT);
    send_ticks(gap_setting);
    frame_body = {8'h33, FC_READ_HOLDING, 8'hFF};
    repeat (255) frame_body = {frame_body, 8'($urandom_range(255))};
    send_frame(1'b0, WHOLE_FRAME, 0, 0, 0);
    random_frames(120);
    settle();

    write_gap_limit(16'd12);
    stall_request = 1'b1;
    random_frames(150);
    settle();

    if (mismatches == 0 && expected_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
